// File: rtl/srwl_pkg.sv
// Shared types and constants for the striped readers-writer lock manager.
// Stream field layout, operation and status codes, controller states.
// No dependencies.
`default_nettype none

package srwl_pkg;

  // Stream widths (fields packed from bit 0 up, padded to whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_W       = 9;
  localparam int BUCKET_W    = 8;
  localparam int STRIPE_W    = 3;
  localparam int WOKEN_W     = 8;

  typedef enum logic [1:0] {
    OP_START_READ  = 2'd0,
    OP_DONE_READ   = 2'd1,
    OP_START_WRITE = 2'd2,
    OP_DONE_WRITE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_QUEUED   = 2'd1,
    ST_NOT_HELD = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    WK_NONE    = 2'd0,
    WK_WRITER  = 2'd1,
    WK_READERS = 2'd2
  } wake_t;

  typedef enum logic [1:0] {
    FSM_BUILD = 2'd0,
    FSM_IDLE  = 2'd1,
    FSM_MAP   = 2'd2,
    FSM_STATE = 2'd3
  } fsm_t;

endpackage

`default_nettype wire

// File: rtl/srwl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module srwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/striped_rw_lock_manager.sv
// An input transfer passes through the bucket map read, the stripe read, then update and write-back
// into the output register; the next item is not taken until the current one has been written back.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous) clears all stripe counters, sets stripe_size to 1 and
// rebuilds the bucket-to-stripe table over all min(NUM_BUCKETS,256) entries with in_tready low.
// Every cfg write triggers the same rebuild.
`default_nettype none

module striped_rw_lock_manager #(
  parameter int NUM_STRIPES = 8,
  parameter int NUM_BUCKETS = 256,
  parameter int COUNT_MAX   = 255
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration: stripe_size
  input  wire logic                              cfg_wr_en,
  input  wire logic [srwl_pkg::CFG_W-1:0]        cfg_wr_data,
  // requests; tdata: operation[1:0], bucket[9:2], zero pad
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [srwl_pkg::IN_TDATA_W-1:0]   in_tdata,
  // results; tdata: status[1:0], stripe[4:2], wake_kind[6:5], readers_woken[14:7], pad
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [srwl_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import srwl_pkg::*;

  localparam int SW        = (NUM_STRIPES > 1) ? $clog2(NUM_STRIPES) : 1;
  localparam int CW        = $clog2(COUNT_MAX + 1);
  localparam int MAP_DEPTH = (NUM_BUCKETS < 256) ? NUM_BUCKETS : 256;
  localparam int MAW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int ENT_W     = 3 * CW + 1;

  localparam logic [CW-1:0]  CMAX       = CW'(COUNT_MAX);
  localparam logic [SW-1:0]  LAST_STRIPE = SW'(NUM_STRIPES - 1);
  localparam logic [MAW-1:0] LAST_MAP    = MAW'(MAP_DEPTH - 1);
  localparam logic [16:0]    LAST_MAP_X  = 17'(MAP_DEPTH - 1);

  typedef struct packed {
    logic [CW-1:0] ar;  // active readers
    logic          wa;  // writer active
    logic [CW-1:0] wr;  // waiting readers
    logic [CW-1:0] ww;  // waiting writers
  } entry_t;

  // control and payload registers
  fsm_t             fsm_r, fsm_nxt;
  logic [8:0]       stripe_size_r, stripe_size_nxt;
  logic [MAW-1:0]   bcnt_r, bcnt_nxt;
  logic [SW-1:0]    q_r, q_nxt;
  logic [8:0]       rem_r, rem_nxt;
  op_t              op_r, op_nxt;
  logic [SW-1:0]    stripe_r, stripe_nxt;
  logic [NUM_STRIPES-1:0] vld_r, vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // RAM ports
  logic             map_we, map_re;
  logic [MAW-1:0]   map_raddr;
  logic [SW-1:0]    map_rdata;
  logic             st_we, st_re;
  logic [ENT_W-1:0] st_rdata;

  logic [16:0]      bucket_x;
  logic [MAW-1:0]   bucket_c;
  logic [8:0]       sz_eff;

  entry_t           cur, nx;
  status_t          status;
  wake_t            kind;
  logic [CW-1:0]    woken;
  logic [CW-1:0]    room;
  logic             do_wake;
  logic [CW+7:0]    woken_x;
  logic [SW+2:0]    stripe_x;
  logic             result_go;

  // bucket clamp and the effective stripe size
  assign bucket_x = {9'b0, in_tdata[9:2]};
  assign bucket_c = (bucket_x > LAST_MAP_X) ? LAST_MAP : bucket_x[MAW-1:0];
  assign sz_eff   = (stripe_size_r == 9'd0) ? 9'd1 : stripe_size_r;

  srwl_ram #(.WIDTH(SW), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (bcnt_r),
    .wdata (q_r),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  srwl_ram #(.WIDTH(ENT_W), .DEPTH(NUM_STRIPES)) u_stripe_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (stripe_r),
    .wdata (nx),
    .re    (st_re),
    .raddr (map_rdata),
    .rdata (st_rdata)
  );

  // read-modify-write of one stripe entry; an entry never written reads as zero
  always_comb begin
    cur     = vld_r[stripe_r] ? entry_t'(st_rdata) : '0;
    nx      = cur;
    status  = ST_OK;
    kind    = WK_NONE;
    woken   = '0;
    do_wake = 1'b0;
    room    = '0;
    unique case (op_r)
      OP_START_READ: begin
        if (cur.wa || cur.ww != '0) begin
          if (cur.wr >= CMAX) begin
            status = ST_FULL;
          end else begin
            nx.wr  = cur.wr + 1'b1;
            status = ST_QUEUED;
          end
        end else if (cur.ar >= CMAX) begin
          status = ST_FULL;
        end else begin
          nx.ar = cur.ar + 1'b1;
        end
      end
      OP_DONE_READ: begin
        if (cur.ar == '0) begin
          status = ST_NOT_HELD;
        end else begin
          nx.ar   = cur.ar - 1'b1;
          do_wake = 1'b1;
        end
      end
      OP_START_WRITE: begin
        if (cur.wa || cur.ar != '0) begin
          if (cur.ww >= CMAX) begin
            status = ST_FULL;
          end else begin
            nx.ww  = cur.ww + 1'b1;
            status = ST_QUEUED;
          end
        end else begin
          nx.wa = 1'b1;
        end
      end
      OP_DONE_WRITE: begin
        if (!cur.wa) begin
          status = ST_NOT_HELD;
        end else begin
          nx.wa   = 1'b0;
          do_wake = 1'b1;
        end
      end
      default: status = ST_OK;
    endcase

    // hand the stripe on: one writer first, else as many readers as fit
    if (do_wake && !nx.wa) begin
      room = CMAX - nx.ar;
      if (nx.ww != '0) begin
        if (nx.ar == '0) begin
          nx.ww = nx.ww - 1'b1;
          nx.wa = 1'b1;
          kind  = WK_WRITER;
        end
      end else if (nx.wr != '0) begin
        woken = (nx.wr < room) ? nx.wr : room;
        if (woken != '0) begin
          nx.wr = nx.wr - woken;
          nx.ar = nx.ar + woken;
          kind  = WK_READERS;
        end
      end
    end
  end

  assign woken_x  = {8'b0, woken};
  assign stripe_x = {3'b0, stripe_r};

  // controller: table build, then map read, stripe read, update
  always_comb begin
    fsm_nxt         = fsm_r;
    stripe_size_nxt = stripe_size_r;
    bcnt_nxt        = bcnt_r;
    q_nxt           = q_r;
    rem_nxt         = rem_r;
    op_nxt          = op_r;
    stripe_nxt      = stripe_r;
    vld_nxt         = vld_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    in_tready       = 1'b0;
    map_we          = 1'b0;
    map_re          = 1'b0;
    map_raddr       = bucket_c;
    st_re           = 1'b0;
    st_we           = 1'b0;
    result_go       = 1'b0;

    unique case (fsm_r)
      FSM_BUILD: begin
        map_we   = 1'b1;
        bcnt_nxt = bcnt_r + 1'b1;
        if (rem_r + 9'd1 == sz_eff) begin
          rem_nxt = 9'd0;
          q_nxt   = (q_r == LAST_STRIPE) ? q_r : q_r + 1'b1;
        end else begin
          rem_nxt = rem_r + 9'd1;
        end
        if (bcnt_r == LAST_MAP) begin
          fsm_nxt = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        in_tready = !cfg_wr_en;
        if (in_tvalid && !cfg_wr_en) begin
          map_re  = 1'b1;
          op_nxt  = op_t'(in_tdata[1:0]);
          fsm_nxt = FSM_MAP;
        end
      end
      FSM_MAP: begin
        st_re      = 1'b1;
        stripe_nxt = map_rdata;
        fsm_nxt    = FSM_STATE;
      end
      FSM_STATE: begin
        if (!out_valid_r || out_tready) begin
          result_go        = 1'b1;
          st_we            = 1'b1;
          vld_nxt[stripe_r] = 1'b1;
          out_valid_nxt    = 1'b1;
          out_data_nxt     = {1'b0, woken_x[7:0], kind, stripe_x[2:0], status};
          fsm_nxt          = FSM_IDLE;
        end
      end
      default: fsm_nxt = FSM_IDLE;
    endcase

    // a new stripe size restarts the table build
    if (cfg_wr_en) begin
      stripe_size_nxt = cfg_wr_data;
      fsm_nxt         = FSM_BUILD;
      bcnt_nxt        = '0;
      q_nxt           = '0;
      rem_nxt         = 9'd0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r         <= FSM_BUILD;
      stripe_size_r <= 9'd1;
      bcnt_r        <= '0;
      q_r           <= '0;
      rem_r         <= 9'd0;
      vld_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      fsm_r         <= fsm_nxt;
      stripe_size_r <= stripe_size_nxt;
      bcnt_r        <= bcnt_nxt;
      q_r           <= q_nxt;
      rem_r         <= rem_nxt;
      vld_r         <= vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    stripe_r   <= stripe_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // an accepted request goes straight to the map read
  a_accept_to_map: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !cfg_wr_en) |=> (fsm_r == FSM_MAP))
    else $error("accepted request did not start its map read");

  // a written-back stripe never holds a writer together with active readers
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> !(nx.wa && nx.ar != '0))
    else $error("writer and readers active on one stripe");

  // woken readers are reported only with a reader wake
  a_woken_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:7] == 8'd0 || out_tdata[6:5] == WK_READERS))
    else $error("readers_woken without reader wake");

  // a queued request never wakes anyone
  a_queued_no_wake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1:0] == ST_QUEUED) |-> (out_tdata[6:5] == WK_NONE))
    else $error("queued request reported a wake");

  // a result is produced only when the output register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    result_go |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken result");
`endif

endmodule

`default_nettype wire
